// ----- design/rtp_sequence_number_assigner_assert.svh -----
// Assertion macros used by the checker file.
// Each use stands on a line of its own.
`ifndef RTP_SEQUENCE_NUMBER_ASSIGNER_ASSERT_SVH
`define RTP_SEQUENCE_NUMBER_ASSIGNER_ASSERT_SVH

// Same-cycle implication, masked while in reset.
`define RSNA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while in reset.
`define RSNA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rtpsna_pkg.sv -----
// ----------------------------------------------------------------------------
// rtpsna_pkg
// Types, codes and helpers shared by the RTP sequence number assigner.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpsna_pkg;

  // packet kinds (kind 3 behaves as media)
  localparam logic [1:0] KIND_MEDIA   = 2'd0;
  localparam logic [1:0] KIND_RTX     = 2'd1;
  localparam logic [1:0] KIND_PADDING = 2'd2;

  localparam logic [7:0]  PT_UNKNOWN   = 8'hFF;
  localparam logic [15:0] NUMBER_RESET = 16'd1;

  typedef enum logic [1:0] {
    STAT_SEQUENCED      = 2'd0,
    STAT_RTX_IGNORED    = 2'd1,
    STAT_UNKNOWN_STREAM = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    REG_MEDIA_STREAM_ID       = 4'd0,
    REG_RESEND_STREAM_ID      = 4'd1,
    REG_RESEND_STREAM_PRESENT = 4'd2,
    REG_MARKER_BEFORE_PADDING = 4'd3,
    REG_MEDIA_NUMBER_START    = 4'd4,
    REG_RESEND_NUMBER_START   = 4'd5,
    REG_START_MEDIA_TIMESTAMP = 4'd6,
    REG_START_CAPTURE_MS      = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        en;
    logic [3:0]  index;
    logic [39:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [31:0] stream_id;
    logic [1:0]  packet_kind;
    logic        marker;
    logic [6:0]  payload_kind;
    logic        red_wrapped;
    logic [7:0]  red_first_byte;
    logic        payload_nonempty;
    logic [31:0] media_timestamp_in;
    logic [39:0] capture_ms_in;
    logic [39:0] now_ms;
    logic [31:0] now_ticks;   // 90 * now_ms, mod 2^32
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] seq_number;
    logic [31:0] media_timestamp_out;
    logic [7:0]  payload_kind_out;
    logic [39:0] capture_ms_out;
    logic        padding_violation;
    logic        media_padding_allowed;
    logic [15:0] next_media_number;
    logic [31:0] last_media_timestamp;
  } result_t;

  // ms to RTP ticks at 90 kHz, low 32 bits: 90 = 64 + 16 + 8 + 2
  function automatic logic [31:0] ms_to_ticks(input logic [39:0] ms);
    logic [31:0] m;
    m = ms[31:0];
    return (m << 6) + (m << 4) + (m << 3) + (m << 1);
  endfunction

endpackage

`default_nettype wire

// ----- design/rtpsna_in_reg.sv -----
// ----------------------------------------------------------------------------
// rtpsna_in_reg
// Input register: captures one descriptor beat and its time in RTP ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpsna_in_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [31:0]         stream_id,
  input  wire logic [1:0]          packet_kind,
  input  wire logic                marker,
  input  wire logic [6:0]          payload_kind,
  input  wire logic                red_wrapped,
  input  wire logic [7:0]          red_first_byte,
  input  wire logic                payload_nonempty,
  input  wire logic [31:0]         media_timestamp_in,
  input  wire logic [39:0]         capture_ms_in,
  input  wire logic [39:0]         now_ms,
  input  wire logic                advance,
  output logic                     item_valid,
  output rtpsna_pkg::item_t        item
);

  logic take;

  assign in_ready = !item_valid || advance;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.stream_id          <= stream_id;
      item.packet_kind        <= packet_kind;
      item.marker             <= marker;
      item.payload_kind       <= payload_kind;
      item.red_wrapped        <= red_wrapped;
      item.red_first_byte     <= red_first_byte;
      item.payload_nonempty   <= payload_nonempty;
      item.media_timestamp_in <= media_timestamp_in;
      item.capture_ms_in      <= capture_ms_in;
      item.now_ms             <= now_ms;
      item.now_ticks          <= rtpsna_pkg::ms_to_ticks(now_ms);
    end
  end

endmodule

`default_nettype wire

// ----- design/rtpsna_core.sv -----
// ----------------------------------------------------------------------------
// rtpsna_core
// Stream state, configuration registers and the per-packet decision logic.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpsna_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rtpsna_pkg::cfg_wr_t cfg_wr,
  input  wire logic                advance,
  input  wire rtpsna_pkg::item_t   item,
  output rtpsna_pkg::result_t      result
);

  // configuration
  logic [31:0] media_stream_id;
  logic [31:0] resend_stream_id;
  logic        resend_stream_present;
  logic        marker_before_padding;

  // stream state
  logic [15:0] media_counter;
  logic [15:0] resend_counter;
  logic [7:0]  remembered_payload_kind;
  logic        payload_kind_known;
  logic        remembered_marker;
  logic [31:0] remembered_timestamp;
  logic [39:0] remembered_send_ms;
  logic [31:0] remembered_send_ticks;
  logic [39:0] remembered_capture_ms;

  logic        is_media, is_resend;
  logic        kind_rtx, kind_pad;
  logic        allowed;
  logic        media_bump, media_update, resend_bump;
  logic        fill_rtx_pad, time_moved;
  logic [15:0] media_counter_next;
  logic [7:0]  pt_in;

  assign is_media  = (item.stream_id == media_stream_id);
  assign is_resend = !is_media && resend_stream_present &&
                     (item.stream_id == resend_stream_id);
  assign kind_rtx  = (item.packet_kind == rtpsna_pkg::KIND_RTX);
  assign kind_pad  = (item.packet_kind == rtpsna_pkg::KIND_PADDING);
  assign allowed   = payload_kind_known && (!marker_before_padding || remembered_marker);

  assign media_update = is_media && !kind_rtx && !kind_pad;
  assign media_bump   = is_media && !kind_rtx;
  assign resend_bump  = is_resend;
  assign media_counter_next = media_bump ? media_counter + 16'd1 : media_counter;

  assign fill_rtx_pad = is_resend && kind_pad && !item.payload_nonempty;
  // elapsed > 0 only when a media packet was sent and the clock moved past it
  assign time_moved   = (remembered_send_ms != 40'd0) && (item.now_ms > remembered_send_ms);
  assign pt_in        = {1'b0, item.payload_kind};

  always_comb begin
    result.status                = rtpsna_pkg::STAT_SEQUENCED;
    result.seq_number            = 16'd0;
    result.media_timestamp_out   = item.media_timestamp_in;
    result.payload_kind_out      = pt_in;
    result.capture_ms_out        = item.capture_ms_in;
    result.padding_violation     = 1'b0;
    result.media_padding_allowed = allowed;
    result.next_media_number     = media_counter_next;
    result.last_media_timestamp  = remembered_timestamp;

    if (is_media) begin
      if (kind_rtx) begin
        result.status = rtpsna_pkg::STAT_RTX_IGNORED;
      end else if (kind_pad) begin
        result.seq_number          = media_counter;
        result.padding_violation   = !allowed;
        result.media_timestamp_out = remembered_timestamp;
        result.capture_ms_out      = remembered_capture_ms;
        result.payload_kind_out    = payload_kind_known ? remembered_payload_kind
                                                        : rtpsna_pkg::PT_UNKNOWN;
      end else begin
        result.seq_number            = media_counter;
        result.media_padding_allowed = !marker_before_padding || item.marker;
        result.last_media_timestamp  = item.media_timestamp_in;
      end
    end else if (is_resend) begin
      result.seq_number = resend_counter;
      if (fill_rtx_pad) begin
        if (time_moved) begin
          // ts + 90*(now - send) = ts + 90*now - 90*send, all mod 2^32
          result.media_timestamp_out = remembered_timestamp + item.now_ticks
                                       - remembered_send_ticks;
          result.capture_ms_out = (remembered_capture_ms != 40'd0)
                                ? remembered_capture_ms + item.now_ms - remembered_send_ms
                                : remembered_capture_ms;
        end else begin
          result.media_timestamp_out = remembered_timestamp;
          result.capture_ms_out      = remembered_capture_ms;
        end
      end
    end else begin
      result.status = rtpsna_pkg::STAT_UNKNOWN_STREAM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      media_stream_id         <= 32'd0;
      resend_stream_id        <= 32'd0;
      resend_stream_present   <= 1'b0;
      marker_before_padding   <= 1'b0;
      media_counter           <= rtpsna_pkg::NUMBER_RESET;
      resend_counter          <= rtpsna_pkg::NUMBER_RESET;
      remembered_payload_kind <= 8'd0;
      payload_kind_known      <= 1'b0;
      remembered_marker       <= 1'b0;
      remembered_timestamp    <= 32'd0;
      remembered_send_ms      <= 40'd0;
      remembered_send_ticks   <= 32'd0;
      remembered_capture_ms   <= 40'd0;
    end else if (cfg_wr.en) begin
      unique case (cfg_wr.index)
        rtpsna_pkg::REG_MEDIA_STREAM_ID:       media_stream_id       <= cfg_wr.data[31:0];
        rtpsna_pkg::REG_RESEND_STREAM_ID:      resend_stream_id      <= cfg_wr.data[31:0];
        rtpsna_pkg::REG_RESEND_STREAM_PRESENT: resend_stream_present <= cfg_wr.data[0];
        rtpsna_pkg::REG_MARKER_BEFORE_PADDING: marker_before_padding <= cfg_wr.data[0];
        rtpsna_pkg::REG_MEDIA_NUMBER_START:    media_counter         <= cfg_wr.data[15:0];
        rtpsna_pkg::REG_RESEND_NUMBER_START:   resend_counter        <= cfg_wr.data[15:0];
        rtpsna_pkg::REG_START_MEDIA_TIMESTAMP: remembered_timestamp  <= cfg_wr.data[31:0];
        rtpsna_pkg::REG_START_CAPTURE_MS:      remembered_capture_ms <= cfg_wr.data;
        default: ;
      endcase
    end else if (advance) begin
      media_counter <= media_counter_next;
      if (resend_bump) begin
        resend_counter <= resend_counter + 16'd1;
      end
      if (media_update) begin
        remembered_marker       <= item.marker;
        remembered_payload_kind <= item.red_wrapped ? item.red_first_byte : pt_in;
        payload_kind_known      <= 1'b1;
        remembered_timestamp    <= item.media_timestamp_in;
        remembered_send_ms      <= item.now_ms;
        remembered_send_ticks   <= item.now_ticks;
        remembered_capture_ms   <= item.capture_ms_in;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/rtpsna_out_reg.sv -----
// ----------------------------------------------------------------------------
// rtpsna_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpsna_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire rtpsna_pkg::result_t  result,
  output logic                      space,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rtpsna_pkg::result_t       held
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

`default_nettype wire

// ----- design/rtp_sequence_number_assigner.sv -----
// ----------------------------------------------------------------------------
// rtp_sequence_number_assigner
// Hands out RTP sequence numbers for a media stream and its RTX stream.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one outgoing packet descriptor per
//    beat. Output channel (out_valid/out_ready): one result beat per input.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//    write only while no packet is in flight. Writes to the start registers
//    load the counters and the remembered timestamp / capture time at once.
//  - Path: an accepted beat sits in the input register, passes the core logic
//    and enters the result register when that has space, showing on out_valid.
//  - Throughput: one descriptor per cycle unless stalled. All per-packet work,
//    including the RTX padding time catch-up, fits between the two registers;
//    the 90x scaling of now_ms is done as the beat enters the input register.
//  - Reset (rst, synchronous): both counters go to 1, the packet memory and
//    config are cleared, the valid flags clear and the channels go idle.
//  - Receiver stall: the result register holds its beat; the input register
//    takes one more beat, then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_sequence_number_assigner (
  input  wire logic        clk,
  input  wire logic        rst,
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [39:0] cfg_data,
  // descriptor channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] stream_id,
  input  wire logic [1:0]  packet_kind,
  input  wire logic        marker,
  input  wire logic [6:0]  payload_kind,
  input  wire logic        red_wrapped,
  input  wire logic [7:0]  red_first_byte,
  input  wire logic        payload_nonempty,
  input  wire logic [31:0] media_timestamp_in,
  input  wire logic [39:0] capture_ms_in,
  input  wire logic [39:0] now_ms,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [15:0]      seq_number,
  output logic [31:0]      media_timestamp_out,
  output logic [7:0]       payload_kind_out,
  output logic [39:0]      capture_ms_out,
  output logic             padding_violation,
  output logic             media_padding_allowed,
  output logic [15:0]      next_media_number,
  output logic [31:0]      last_media_timestamp
);

  rtpsna_pkg::cfg_wr_t cfg_wr;
  rtpsna_pkg::item_t   item;
  rtpsna_pkg::result_t result;
  rtpsna_pkg::result_t held;
  logic                item_valid;
  logic                space;
  logic                advance;

  // config beats are taken every cycle
  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // an item moves into the result register whenever that register frees up
  assign advance = item_valid && space;

  rtpsna_in_reg u_in_reg (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .stream_id          (stream_id),
    .packet_kind        (packet_kind),
    .marker             (marker),
    .payload_kind       (payload_kind),
    .red_wrapped        (red_wrapped),
    .red_first_byte     (red_first_byte),
    .payload_nonempty   (payload_nonempty),
    .media_timestamp_in (media_timestamp_in),
    .capture_ms_in      (capture_ms_in),
    .now_ms             (now_ms),
    .advance            (advance),
    .item_valid         (item_valid),
    .item               (item)
  );

  rtpsna_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg_wr  (cfg_wr),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  rtpsna_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign status                = held.status;
  assign seq_number            = held.seq_number;
  assign media_timestamp_out   = held.media_timestamp_out;
  assign payload_kind_out      = held.payload_kind_out;
  assign capture_ms_out        = held.capture_ms_out;
  assign padding_violation     = held.padding_violation;
  assign media_padding_allowed = held.media_padding_allowed;
  assign next_media_number     = held.next_media_number;
  assign last_media_timestamp  = held.last_media_timestamp;

endmodule

`default_nettype wire

// ----- design/rtpsna_checker.sv -----
// ----------------------------------------------------------------------------
// rtpsna_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rtp_sequence_number_assigner_assert.svh"

module rtpsna_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [15:0] seq_number,
  input wire logic        padding_violation,
  input wire logic        media_padding_allowed,
  input wire logic [15:0] next_media_number
);

  logic stalled;
  logic not_sequenced;

  assign stalled       = out_valid && !out_ready;
  assign not_sequenced = (status == rtpsna_pkg::STAT_RTX_IGNORED) ||
                         (status == rtpsna_pkg::STAT_UNKNOWN_STREAM);

  // a stalled beat holds
  `RSNA_ASSERT_NEXT(a_out_hold, clk, rst, stalled, out_valid && $stable(seq_number) && $stable(status) && $stable(next_media_number), "result beat changed while stalled")

  // dropped or unknown packets carry no number and no flag
  `RSNA_ASSERT_IMPL(a_unseq_clean, clk, rst, out_valid && not_sequenced, seq_number == 16'd0 && !padding_violation, "unsequenced beat carries a number or flag")

  // a violation leaves padding still not allowed
  `RSNA_ASSERT_IMPL(a_viol_state, clk, rst, out_valid && padding_violation, !media_padding_allowed && status == rtpsna_pkg::STAT_SEQUENCED, "padding violation with inconsistent state")

  // media padding bumps the media counter past the number it hands out
  `RSNA_ASSERT_IMPL(a_viol_bump, clk, rst, out_valid && padding_violation, next_media_number == seq_number + 16'd1, "padding did not advance the media counter")

endmodule

bind rtp_sequence_number_assigner rtpsna_checker u_rtpsna_checker (
  .clk                   (clk),
  .rst                   (rst),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .status                (status),
  .seq_number            (seq_number),
  .padding_violation     (padding_violation),
  .media_padding_allowed (media_padding_allowed),
  .next_media_number     (next_media_number)
);

`default_nettype wire
